// ===== src/mmx_pkg.sv =====
// shared types, constants and throttle limit function for the quad x motor mixer
`default_nettype none
package mmx_pkg;

   localparam int ROTOR_COUNT = 4;
   localparam int THR_W      = 8;
   localparam int Q_W        = 16;
   localparam int SUM_W      = 24;
   localparam int FRAC_BITS  = 14;
   localparam int Q_ONE      = 16384;
   localparam int FULL_SCALE = 255 * Q_ONE;

   localparam int COEF_THRUST = 255;
   localparam int COEF_ROLL   = 50;
   localparam int COEF_PITCH  = 50;
   localparam int COEF_YAW    = 30;

   // motor slots
   localparam int ROTOR_FR = 0;
   localparam int ROTOR_RR = 1;
   localparam int ROTOR_RL = 2;
   localparam int ROTOR_FL = 3;

   typedef enum logic [2:0] {
      KIND_ARM     = 3'd0,
      KIND_DISARM  = 3'd1,
      KIND_SET_ONE = 3'd2,
      KIND_SET_ALL = 3'd3,
      KIND_MIX     = 3'd4,
      KIND_ESTOP   = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      REG_MIN_THROTTLE  = 2'd0,
      REG_MAX_THROTTLE  = 2'd1,
      REG_IDLE_THROTTLE = 2'd2
   } reg_index_type;

   typedef logic [THR_W-1:0] throttle_type;
   typedef throttle_type [ROTOR_COUNT-1:0] motor_set_type;

   typedef struct packed {
      throttle_type min_thr;
      throttle_type max_thr;
   } limits_type;

   function automatic throttle_type limit_throttle(throttle_type t, limits_type lim);
      throttle_type r;
      if (t < lim.min_thr) begin
         r = lim.min_thr;
      end else if (t > lim.max_thr) begin
         r = lim.max_thr;
      end else begin
         r = t;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/mmx_mix.sv =====
// x-quad mixing of thrust, roll, pitch and yaw into four limited throttles
`default_nettype none
module mmx_mix (
   input  wire logic signed [mmx_pkg::Q_W-1:0] thrust,
   input  wire logic signed [mmx_pkg::Q_W-1:0] roll,
   input  wire logic signed [mmx_pkg::Q_W-1:0] pitch,
   input  wire logic signed [mmx_pkg::Q_W-1:0] yaw,
   input  wire mmx_pkg::limits_type             limits,
   output      mmx_pkg::motor_set_type          throttle
);

   localparam int QW = mmx_pkg::Q_W;
   localparam int SW = mmx_pkg::SUM_W;
   localparam logic signed [QW-1:0] QP = QW'(mmx_pkg::Q_ONE);
   localparam logic signed [QW-1:0] QN = -QW'(mmx_pkg::Q_ONE);
   localparam logic signed [SW-1:0] FULL = SW'(mmx_pkg::FULL_SCALE);
   localparam logic signed [SW-1:0] K_T = SW'(mmx_pkg::COEF_THRUST);
   localparam logic signed [SW-1:0] K_R = SW'(mmx_pkg::COEF_ROLL);
   localparam logic signed [SW-1:0] K_P = SW'(mmx_pkg::COEF_PITCH);
   localparam logic signed [SW-1:0] K_Y = SW'(mmx_pkg::COEF_YAW);

   logic signed [QW-1:0] thr_c, roll_c, pitch_c, yaw_c;
   logic signed [SW-1:0] thr_x, roll_x, pitch_x, yaw_x;
   logic signed [SW-1:0] thr_m, roll_m, pitch_m, yaw_m;
   logic signed [SW-1:0] sum [mmx_pkg::ROTOR_COUNT];

   function automatic logic signed [QW-1:0] clamp_axis(logic signed [QW-1:0] v,
                                                      logic signed [QW-1:0] lo);
      logic signed [QW-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > QP) begin
         r = QP;
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_comb begin
      thr_c   = clamp_axis(thrust, '0);
      roll_c  = clamp_axis(roll, QN);
      pitch_c = clamp_axis(pitch, QN);
      yaw_c   = clamp_axis(yaw, QN);
      thr_x   = {{(SW-QW){thr_c[QW-1]}}, thr_c};
      roll_x  = {{(SW-QW){roll_c[QW-1]}}, roll_c};
      pitch_x = {{(SW-QW){pitch_c[QW-1]}}, pitch_c};
      yaw_x   = {{(SW-QW){yaw_c[QW-1]}}, yaw_c};
      thr_m   = thr_x * K_T;
      roll_m  = roll_x * K_R;
      pitch_m = pitch_x * K_P;
      yaw_m   = yaw_x * K_Y;
      sum[mmx_pkg::ROTOR_FR] = thr_m - roll_m + pitch_m + yaw_m;
      sum[mmx_pkg::ROTOR_RR] = thr_m - roll_m - pitch_m - yaw_m;
      sum[mmx_pkg::ROTOR_RL] = thr_m + roll_m - pitch_m + yaw_m;
      sum[mmx_pkg::ROTOR_FL] = thr_m + roll_m + pitch_m - yaw_m;
   end

   for (genvar m = 0; m < mmx_pkg::ROTOR_COUNT; m++) begin : g_sat
      mmx_pkg::throttle_type sat;
      always_comb begin
         if (sum[m] < 0) begin
            sat = '0;
         end else if (sum[m] > FULL) begin
            sat = '1;
         end else begin
            sat = sum[m][mmx_pkg::FRAC_BITS +: mmx_pkg::THR_W];
         end
         throttle[m] = mmx_pkg::limit_throttle(sat, limits);
      end
   end

endmodule
`default_nettype wire

// ===== src/quad_x_motor_mixer_with_arming.sv =====
// top level of the quad x motor mixer with arming
// Usage:
//  - req_ channel: one command per transaction (arm, disarm, set one, set all,
//    mix, emergency stop), taken when req_valid is high and req_stall is low
//  - rsp_ channel: exactly one transaction per command, carrying the four motor
//    duties and the armed flag as they stand after that command
//  - csr_ channel: writes min, max and idle throttle; always ready; the user must
//    see it written only while no command is in flight; not enforced by the block
//  - apply: an accepted command waits in the command register and is applied
//    from there to the throttle registers, which hold its valid response
//  - throughput: one command per cycle while the response is not stalled; the
//    whole update of the armed flag and throttles is combinational between the
//    command register and the throttle registers, which also drive the response
//  - reset: disarmed, all throttles zero, min 0, max 255, idle 0, both
//    channels empty
//  - rsp_stall holds the response; one more command waits in the command
//    register, after which req_stall rises until the response is taken
`default_nettype none
module quad_x_motor_mixer_with_arming (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [1:0]  req_motor_index,
   input  wire logic [7:0]  req_value_a,
   input  wire logic [7:0]  req_value_b,
   input  wire logic [7:0]  req_value_c,
   input  wire logic [7:0]  req_value_d,
   input  wire logic signed [15:0] req_thrust,
   input  wire logic signed [15:0] req_roll,
   input  wire logic signed [15:0] req_pitch,
   input  wire logic signed [15:0] req_yaw,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_duty_front_right,
   output      logic [7:0]  rsp_duty_rear_right,
   output      logic [7:0]  rsp_duty_rear_left,
   output      logic [7:0]  rsp_duty_front_left,
   output      logic        rsp_is_armed,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   // command register
   logic                  cmd_valid_ff, cmd_valid_in;
   logic [2:0]            cmd_kind_ff;
   logic [1:0]            cmd_index_ff;
   mmx_pkg::motor_set_type cmd_value_ff;
   logic signed [15:0]    cmd_thrust_ff, cmd_roll_ff, cmd_pitch_ff, cmd_yaw_ff;

   // state and response
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  armed_ff, armed_in;
   mmx_pkg::motor_set_type throttle_ff, throttle_in;

   // configuration
   mmx_pkg::throttle_type min_ff, max_ff, idle_ff;

   mmx_pkg::limits_type   limits;
   mmx_pkg::motor_set_type mix_thr;
   logic                  advance, fire, req_take;

   assign limits    = '{min_thr: min_ff, max_thr: max_ff};
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = cmd_valid_ff && advance;
   assign req_stall = cmd_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_duty_front_right = throttle_ff[mmx_pkg::ROTOR_FR];
   assign rsp_duty_rear_right  = throttle_ff[mmx_pkg::ROTOR_RR];
   assign rsp_duty_rear_left   = throttle_ff[mmx_pkg::ROTOR_RL];
   assign rsp_duty_front_left  = throttle_ff[mmx_pkg::ROTOR_FL];
   assign rsp_is_armed         = armed_ff;

   mmx_mix u_mix (
      .thrust   (cmd_thrust_ff),
      .roll     (cmd_roll_ff),
      .pitch    (cmd_pitch_ff),
      .yaw      (cmd_yaw_ff),
      .limits   (limits),
      .throttle (mix_thr)
   );

   always_comb begin
      cmd_valid_in = req_stall ? cmd_valid_ff : req_valid;
      rsp_valid_in = advance ? cmd_valid_ff : rsp_valid_ff;
      armed_in     = armed_ff;
      throttle_in  = throttle_ff;
      if (fire) begin
         case (mmx_pkg::kind_type'(cmd_kind_ff))
            mmx_pkg::KIND_ARM: begin
               armed_in = 1'b1;
               for (int m = 0; m < mmx_pkg::ROTOR_COUNT; m++) begin
                  throttle_in[m] = idle_ff;
               end
            end
            mmx_pkg::KIND_DISARM, mmx_pkg::KIND_ESTOP: begin
               armed_in    = 1'b0;
               throttle_in = '0;
            end
            mmx_pkg::KIND_SET_ONE: begin
               if (armed_ff) begin
                  throttle_in[cmd_index_ff] =
                     mmx_pkg::limit_throttle(cmd_value_ff[mmx_pkg::ROTOR_FR], limits);
               end
            end
            mmx_pkg::KIND_SET_ALL: begin
               if (armed_ff) begin
                  for (int m = 0; m < mmx_pkg::ROTOR_COUNT; m++) begin
                     throttle_in[m] = mmx_pkg::limit_throttle(cmd_value_ff[m], limits);
                  end
               end
            end
            mmx_pkg::KIND_MIX: begin
               if (armed_ff) begin
                  throttle_in = mix_thr;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         armed_ff     <= 1'b0;
         throttle_ff  <= '0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         armed_ff     <= armed_in;
         throttle_ff  <= throttle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_kind_ff  <= req_kind;
         cmd_index_ff <= req_motor_index;
         cmd_value_ff[mmx_pkg::ROTOR_FR] <= req_value_a;
         cmd_value_ff[mmx_pkg::ROTOR_RR] <= req_value_b;
         cmd_value_ff[mmx_pkg::ROTOR_RL] <= req_value_c;
         cmd_value_ff[mmx_pkg::ROTOR_FL] <= req_value_d;
         cmd_thrust_ff <= req_thrust;
         cmd_roll_ff   <= req_roll;
         cmd_pitch_ff  <= req_pitch;
         cmd_yaw_ff    <= req_yaw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         max_ff  <= '1;
         idle_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (mmx_pkg::reg_index_type'(csr_index))
            mmx_pkg::REG_MIN_THROTTLE:  min_ff  <= csr_wdata;
            mmx_pkg::REG_MAX_THROTTLE:  max_ff  <= csr_wdata;
            mmx_pkg::REG_IDLE_THROTTLE: idle_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // disarmed motors are always at zero
   a_disarmed_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (throttle_ff == '0))
      else $error("motors not zero while disarmed");

   // state moves only when a transaction is applied
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(throttle_ff) && $stable(armed_ff)))
      else $error("state changed without a transaction");

   // backpressure only with a full command register
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (cmd_valid_ff && rsp_valid_ff))
      else $error("req_stall without a held transaction");

endmodule
`default_nettype wire
